// File: sv/lcbp_pkg.sv
// Shared types, constants and code tables of the lowpass coded block pattern coder.
package lcbp_pkg;

   localparam int MAX_COMPONENTS = 16;
   localparam int FLAG_WIDTH     = 16;
   localparam int LEN_WIDTH      = 5;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 5;
   localparam int TALLY_WIDTH    = 4;

   localparam logic signed [TALLY_WIDTH-1:0] TALLY_RESET = 4'sd1;
   localparam logic signed [TALLY_WIDTH:0]   TALLY_MIN   = -5'sd8;
   localparam logic signed [TALLY_WIDTH:0]   TALLY_MAX   = 5'sd7;

   localparam logic [4:0] COUNT_RESET = 5'd3;

   typedef enum logic [1:0] {
      FMT_YUV444 = 2'd0,
      FMT_YUV422 = 2'd1,
      FMT_YUV420 = 2'd2,
      FMT_OTHER  = 2'd3
   } fmt_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_COLOR_FORMAT    = 2'd0,
      CSR_COMPONENT_COUNT = 2'd1,
      CSR_SPARE_2         = 2'd2,
      CSR_SPARE_3         = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [3:0]           bits;
      logic [LEN_WIDTH-1:0] len;
   } vlc_type;

   function automatic vlc_type vlc444(input logic [2:0] idx);
      vlc_type v;
      case (idx)
         3'd0:    v = '{bits: 4'h0, len: 5'd1};
         3'd1:    v = '{bits: 4'h4, len: 5'd3};
         3'd2:    v = '{bits: 4'ha, len: 5'd4};
         3'd3:    v = '{bits: 4'hb, len: 5'd4};
         3'd4:    v = '{bits: 4'hc, len: 5'd4};
         3'd5:    v = '{bits: 4'hd, len: 5'd4};
         3'd6:    v = '{bits: 4'he, len: 5'd4};
         default: v = '{bits: 4'hf, len: 5'd4};
      endcase
      return v;
   endfunction

   function automatic vlc_type vlc42x(input logic [1:0] idx);
      vlc_type v;
      case (idx)
         2'd0:    v = '{bits: 4'h0, len: 5'd1};
         2'd1:    v = '{bits: 4'h2, len: 5'd2};
         2'd2:    v = '{bits: 4'h6, len: 5'd3};
         default: v = '{bits: 4'h7, len: 5'd3};
      endcase
      return v;
   endfunction

   // Saturating tally step: add one, or take three away on a hit.
   function automatic logic signed [TALLY_WIDTH-1:0] bump_tally(
      input logic signed [TALLY_WIDTH-1:0] t,
      input logic                          hit
   );
      logic signed [TALLY_WIDTH:0] s;
      s = {t[TALLY_WIDTH-1], t} + (hit ? -5'sd3 : 5'sd1);
      if (s < TALLY_MIN) s = TALLY_MIN;
      if (s > TALLY_MAX) s = TALLY_MAX;
      return s[TALLY_WIDTH-1:0];
   endfunction

endpackage

// File: sv/lcbp_if.sv
// Request and response channel interfaces of the coded block pattern coder.
interface lcbp_req_if import lcbp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FLAG_WIDTH-1:0] plane_nonzero;

   modport source (output valid, output plane_nonzero, input ready);
   modport sink   (input valid, input plane_nonzero, output ready);
endinterface

interface lcbp_rsp_if import lcbp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FLAG_WIDTH-1:0] code_bits;
   logic [LEN_WIDTH-1:0]  code_length;
   logic [FLAG_WIDTH-1:0] pattern;

   modport source (output valid, output code_bits, output code_length, output pattern,
                   input ready);
   modport sink   (input valid, input code_bits, input code_length, input pattern,
                   output ready);
endinterface

// File: sv/lowpass_cbp_adaptive_coder.sv
// Top level of the lowpass coded block pattern coder.
//
//   port   | dir | carries
//   -------+-----+--------------------------------------------------
//   req    | in  | plane_nonzero flags of one macroblock
//   rsp    | out | code_bits, code_length, pattern of that macroblock
//   csr_*  | in  | color_format (index 0), component_count (index 1)
//
// One item per cycle unless rsp stalls; stages: input register, result register.
// The tally feedback closes on the coding of the item in the input register.
// Synchronous reset empties both stages and sets both tallies to one.
// A stall on rsp holds the result register; the input register still fills behind it.
module lowpass_cbp_adaptive_coder import lcbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   lcbp_req_if.sink                  req,
   lcbp_rsp_if.source                rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   fmt_type                        fmt_ff;
   logic [4:0]                     count_ff;
   logic signed [TALLY_WIDTH-1:0]  zero_tally_ff, zero_tally_in;
   logic signed [TALLY_WIDTH-1:0]  max_tally_ff,  max_tally_in;

   logic                           in_valid_ff;
   logic [FLAG_WIDTH-1:0]          in_flags_ff;
   logic                           out_valid_ff;
   logic [FLAG_WIDTH-1:0]          out_code_ff,    out_code_in;
   logic [LEN_WIDTH-1:0]           out_len_ff,     out_len_in;
   logic [FLAG_WIDTH-1:0]          out_pattern_ff, out_pattern_in;

   logic                           out_free;
   logic                           advance;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   assign rsp.valid       = out_valid_ff;
   assign rsp.code_bits   = out_code_ff;
   assign rsp.code_length = out_len_ff;
   assign rsp.pattern     = out_pattern_ff;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_YUV444;
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_COLOR_FORMAT:    fmt_ff   <= fmt_type'(csr_write_data[1:0]);
            CSR_COMPONENT_COUNT: count_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // Coding of the item held in the input register
   always_comb begin
      logic                  full;
      logic [2:0]            maxv;
      logic [2:0]            yuv_pat;
      logic [2:0]            idx;
      logic                  use_vlc;
      vlc_type               v;
      logic [4:0]            cnt;
      logic [FLAG_WIDTH:0]   mask_w;
      logic [FLAG_WIDTH-1:0] masked;
      logic [FLAG_WIDTH-1:0] rev;

      full    = (fmt_ff == FMT_YUV444);
      maxv    = full ? 3'd7 : 3'd3;
      yuv_pat = {full & in_flags_ff[2], in_flags_ff[1] | (!full & in_flags_ff[2]),
                 in_flags_ff[0]};
      use_vlc = (zero_tally_ff <= 4'sd0) || (max_tally_ff < 4'sd0);
      idx     = (max_tally_ff < zero_tally_ff) ? (maxv - yuv_pat) : yuv_pat;
      v       = full ? vlc444(idx) : vlc42x(idx[1:0]);

      // Clamp the component count to 1..MAX_COMPONENTS
      if (count_ff == 5'd0)
         cnt = 5'd1;
      else if (count_ff > 5'(MAX_COMPONENTS))
         cnt = 5'(MAX_COMPONENTS);
      else
         cnt = count_ff;
      mask_w = (17'd1 << cnt) - 17'd1;
      masked = in_flags_ff & mask_w[FLAG_WIDTH-1:0];
      for (int n = 0; n < FLAG_WIDTH; n++) begin
         rev[n] = masked[FLAG_WIDTH-1-n];
      end

      zero_tally_in = zero_tally_ff;
      max_tally_in  = max_tally_ff;
      if (fmt_ff == FMT_OTHER) begin
         out_pattern_in = masked;
         out_code_in    = rev >> (5'(FLAG_WIDTH) - cnt);
         out_len_in     = cnt;
      end else begin
         out_pattern_in = {13'd0, yuv_pat};
         if (use_vlc) begin
            out_code_in = {12'd0, v.bits};
            out_len_in  = v.len;
         end else begin
            out_code_in = {13'd0, yuv_pat};
            out_len_in  = full ? 5'd3 : 5'd2;
         end
         if (advance) begin
            zero_tally_in = bump_tally(zero_tally_ff, yuv_pat == 3'd0);
            max_tally_in  = bump_tally(max_tally_ff,  yuv_pat == maxv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         zero_tally_ff <= TALLY_RESET;
         max_tally_ff  <= TALLY_RESET;
      end else begin
         if (req.ready)
            in_valid_ff <= req.valid;
         if (out_free)
            out_valid_ff <= in_valid_ff;
         zero_tally_ff <= zero_tally_in;
         max_tally_ff  <= max_tally_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready)
         in_flags_ff <= req.plane_nonzero;
      if (advance) begin
         out_code_ff    <= out_code_in;
         out_len_ff     <= out_len_in;
         out_pattern_ff <= out_pattern_in;
      end
   end

endmodule

// File: sv/lcbp_checker.sv
// Port-level checks of the coded block pattern coder, bound to the top level.
module lcbp_checker import lcbp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [FLAG_WIDTH-1:0] rsp_code_bits,
   input logic [LEN_WIDTH-1:0]  rsp_code_length,
   input logic [FLAG_WIDTH-1:0] rsp_pattern
);

   // Hold a stalled item unchanged
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_bits)
         && $stable(rsp_code_length) && $stable(rsp_pattern))
      else $error("stalled result changed");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_length != 5'd0) && (rsp_code_length <= 5'(MAX_COMPONENTS)))
      else $error("code length out of range");

   a_code_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((17'(rsp_code_bits) >> rsp_code_length) == 17'd0))
      else $error("code bits beyond code length");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind lowpass_cbp_adaptive_coder lcbp_checker u_lcbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_code_bits   (rsp.code_bits),
   .rsp_code_length (rsp.code_length),
   .rsp_pattern     (rsp.pattern)
);
